// ===== rtl/ctg_pkg.sv =====
// Shared types, constants and the cosine weight table for the trajectory generator.
package ctg_pkg;

  localparam int MOVE_DEPTH     = 8;
  localparam int COS_TABLE_SIZE = 1024;
  localparam int QIDX_W         = $clog2(MOVE_DEPTH);
  localparam int FILL_W         = $clog2(MOVE_DEPTH + 1);
  localparam int K_W            = $clog2(COS_TABLE_SIZE + 1);
  localparam int W_W            = 17;
  localparam int MAG_W          = 33;
  localparam int OPND_W         = 24;
  localparam int PROD_W         = MAG_W + OPND_W;
  localparam int DIV_W          = 50;
  localparam int DCNT_W         = $clog2(DIV_W + 1);
  localparam int VQ_W           = PROD_W - 16;

  localparam logic [7:0] CFG_START_A  = 8'd0;
  localparam logic [7:0] CFG_START_B  = 8'd1;
  localparam logic [7:0] CFG_VEL_GAIN = 8'd2;

  localparam logic [23:0] VEL_GAIN_RESET = 24'd1820444;

  typedef enum logic [1:0] {
    ACT_LINEAR = 2'd0,
    ACT_COSINE = 2'd1,
    ACT_WAIT   = 2'd2,
    ACT_TICK   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PLAY = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_ENQ, OP_INIT, OP_PREP, OP_MUL_I, OP_DIV_LIN, OP_DIV_K, OP_DIV_STEP,
    OP_Q_LIN, OP_TAB, OP_MUL_W, OP_Q_COS, OP_NXT, OP_DIFF, OP_MUL_V, OP_VEL, OP_OUT
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_MUL_I, S_DIV_LIN, S_DIV_K, S_DIV_RUN, S_Q_LIN, S_TAB,
    S_MUL_W, S_Q_COS, S_NXT, S_DIFF, S_MUL_V, S_VEL, S_OUT
  } state_t;

  typedef struct packed {
    op_t  op;
    logic ax;
  } ctg_cmd_t;

  typedef struct packed {
    action_t head_kind;
    action_t kind;
    logic    no_move;
    logic    vel_en;
    logic    div_done;
    logic    out_free;
    logic    play_done;
  } ctg_status_t;

  typedef logic [W_W-1:0] wtab_t [COS_TABLE_SIZE+1];

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // sin^2 weight in Q16, from a fixed-point Taylor series of the sine.
  function automatic wtab_t build_wtab();
    wtab_t       tab;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] w;
    for (int j = 0; j <= COS_TABLE_SIZE; j++) begin
      u  = (64'(j) * HALF_PI_Q30 + 64'(COS_TABLE_SIZE / 2)) / 64'(COS_TABLE_SIZE);
      u2 = (u * u) >> 30;
      t  = Q30_ONE - u2 / 64'd110;
      t  = Q30_ONE - ((u2 * t) >> 30) / 64'd72;
      t  = Q30_ONE - ((u2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((u2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((u2 * t) >> 30) / 64'd6;
      s  = (u * t) >> 30;
      w  = (s * s + (64'd1 << 43)) >> 44;
      if (w > 64'd65536) begin
        w = 64'd65536;
      end
      tab[j] = w[W_W-1:0];
    end
    tab[0]              = '0;
    tab[COS_TABLE_SIZE] = W_W'(65536);
    return tab;
  endfunction

endpackage

// ===== rtl/ctg_ctrl.sv =====
// Sequencer for the trajectory generator: steps the datapath through each tick.
module ctg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  ctg_pkg::action_t    in_action,
  output logic                s_tready,
  input  ctg_pkg::ctg_status_t status,
  output ctg_pkg::ctg_cmd_t   cmd
);
  import ctg_pkg::*;

  state_t state, state_next;
  logic   ax, ax_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ax    <= 1'b0;
    end else begin
      state <= state_next;
      ax    <= ax_next;
    end
  end

  always_comb begin
    state_next = state;
    ax_next    = ax;
    cmd.op     = OP_NONE;
    cmd.ax     = ax;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (in_action != ACT_TICK) begin
            cmd.op = OP_ENQ;
          end else if (!status.play_done) begin
            cmd.op     = OP_INIT;
            state_next = S_PREP;
          end
        end
      end
      S_PREP: begin
        cmd.op  = OP_PREP;
        ax_next = 1'b0;
        if (status.no_move) begin
          state_next = S_OUT;
        end else begin
          case (status.head_kind)
            ACT_LINEAR: state_next = S_MUL_I;
            ACT_COSINE: state_next = S_DIV_K;
            default:    state_next = S_NXT;
          endcase
        end
      end
      S_MUL_I: begin
        cmd.op     = OP_MUL_I;
        state_next = S_DIV_LIN;
      end
      S_DIV_LIN: begin
        cmd.op     = OP_DIV_LIN;
        state_next = S_DIV_RUN;
      end
      S_DIV_K: begin
        cmd.op     = OP_DIV_K;
        state_next = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        if (status.div_done) begin
          state_next = (status.kind == ACT_COSINE) ? S_TAB : S_Q_LIN;
        end else begin
          cmd.op = OP_DIV_STEP;
        end
      end
      S_Q_LIN: begin
        cmd.op = OP_Q_LIN;
        if (!ax) begin
          ax_next    = 1'b1;
          state_next = S_MUL_I;
        end else begin
          state_next = S_NXT;
        end
      end
      S_TAB: begin
        cmd.op     = OP_TAB;
        ax_next    = 1'b0;
        state_next = S_MUL_W;
      end
      S_MUL_W: begin
        cmd.op     = OP_MUL_W;
        state_next = S_Q_COS;
      end
      S_Q_COS: begin
        cmd.op = OP_Q_COS;
        if (!ax) begin
          ax_next    = 1'b1;
          state_next = S_MUL_W;
        end else begin
          state_next = S_NXT;
        end
      end
      S_NXT: begin
        cmd.op     = OP_NXT;
        state_next = status.vel_en ? S_DIFF : S_OUT;
      end
      S_DIFF: begin
        cmd.op     = OP_DIFF;
        ax_next    = 1'b0;
        state_next = S_MUL_V;
      end
      S_MUL_V: begin
        cmd.op     = OP_MUL_V;
        state_next = S_VEL;
      end
      S_VEL: begin
        cmd.op = OP_VEL;
        if (!ax) begin
          ax_next    = 1'b1;
          state_next = S_MUL_V;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/ctg_datapath.sv =====
// Move queue, sample and velocity arithmetic, serial divider and output register.
module ctg_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  ctg_pkg::ctg_cmd_t    cmd,
  output ctg_pkg::ctg_status_t status,
  input  ctg_pkg::action_t     in_action,
  input  logic signed [31:0]   in_end_a,
  input  logic signed [31:0]   in_end_b,
  input  logic [15:0]          in_count,
  input  logic signed [31:0]   start_a,
  input  logic signed [31:0]   start_b,
  input  logic [23:0]          gain,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [127:0]         m_tdata,
  output logic                 m_tlast,
  output logic [0:0]           m_tuser
);
  import ctg_pkg::*;

  localparam wtab_t WTAB = build_wtab();

  logic signed [31:0] tgt_a_mem [MOVE_DEPTH];
  logic signed [31:0] tgt_b_mem [MOVE_DEPTH];
  action_t            kind_mem  [MOVE_DEPTH];
  logic [15:0]        cnt_mem   [MOVE_DEPTH];

  logic [FILL_W-1:0] fill;
  logic [QIDX_W-1:0] head, tail;
  logic [15:0]       step;
  phase_t            phase;
  logic              ovf;
  logic signed [31:0] origin [2];
  logic signed [31:0] cur    [2];
  logic signed [31:0] prev   [2];
  logic signed [31:0] nxt    [2];
  logic signed [31:0] vel    [2];
  logic [MAG_W-1:0]   mag    [2];
  logic               neg    [2];
  logic [MAG_W-1:0]   q      [2];
  logic [15:0]        i_idx, n_cnt;
  action_t            kind;
  logic               more, vel_en;
  logic [W_W-1:0]     w;
  logic [PROD_W-1:0]  prod;
  logic [DIV_W-1:0]   dvd;
  logic [15:0]        rem;
  logic [DCNT_W-1:0]  dcnt;

  logic signed [31:0] hd_tgt   [2];
  logic signed [31:0] orig_eff [2];
  logic signed [32:0] dpos     [2];
  logic [OPND_W-1:0]  mul_opnd;
  logic [PROD_W-1:0]  prod_c;
  logic [PROD_W-1:0]  prod_rnd;
  logic [VQ_W-1:0]    vq;
  logic [16:0]        rtry;
  logic [K_W-1:0]     k_idx;
  logic               out_load;

  assign hd_tgt[0] = tgt_a_mem[head];
  assign hd_tgt[1] = tgt_b_mem[head];
  assign out_load  = (cmd.op == OP_OUT);

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      orig_eff[a] = (step == '0) ? cur[a] : origin[a];
      dpos[a]     = {hd_tgt[a][31], hd_tgt[a]} - {orig_eff[a][31], orig_eff[a]};
    end
    case (cmd.op)
      OP_MUL_I: mul_opnd = OPND_W'(i_idx);
      OP_MUL_W: mul_opnd = OPND_W'(w);
      default:  mul_opnd = gain;
    endcase
    prod_c   = PROD_W'(mag[cmd.ax]) * PROD_W'(mul_opnd);
    prod_rnd = prod + PROD_W'(32768);
    vq       = prod_rnd[16 +: VQ_W];
    rtry     = {rem, dvd[DIV_W-1]};
    k_idx    = (dvd > DIV_W'(COS_TABLE_SIZE)) ? K_W'(COS_TABLE_SIZE) : dvd[K_W-1:0];
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_ENQ && in_count != '0 && fill != FILL_W'(MOVE_DEPTH)) begin
      tgt_a_mem[tail] <= in_end_a;
      tgt_b_mem[tail] <= in_end_b;
      kind_mem[tail]  <= in_action;
      cnt_mem[tail]   <= in_count;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      head     <= '0;
      tail     <= '0;
      step     <= '0;
      phase    <= PH_IDLE;
      ovf      <= 1'b0;
      dcnt     <= '0;
      m_tvalid <= 1'b0;
      for (int a = 0; a < 2; a++) begin
        origin[a] <= '0;
        cur[a]    <= '0;
        prev[a]   <= '0;
      end
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (cmd.op)
        OP_ENQ: begin
          if (in_count != '0) begin
            if (fill == FILL_W'(MOVE_DEPTH)) begin
              ovf <= 1'b1;
            end else begin
              fill <= fill + 1'b1;
              tail <= (tail == QIDX_W'(MOVE_DEPTH - 1)) ? '0 : tail + 1'b1;
            end
          end
        end
        OP_INIT: begin
          if (phase == PH_IDLE) begin
            cur[0]  <= start_a;
            cur[1]  <= start_b;
            prev[0] <= start_a;
            prev[1] <= start_b;
          end
        end
        OP_PREP: begin
          origin[0] <= orig_eff[0];
          origin[1] <= orig_eff[1];
        end
        OP_DIV_LIN, OP_DIV_K: dcnt <= DCNT_W'(DIV_W);
        OP_DIV_STEP:          dcnt <= dcnt - 1'b1;
        OP_OUT: begin
          if (more) begin
            prev  <= cur;
            cur   <= nxt;
            phase <= PH_PLAY;
            if (i_idx >= n_cnt) begin
              step <= '0;
              fill <= fill - 1'b1;
              head <= (head == QIDX_W'(MOVE_DEPTH - 1)) ? '0 : head + 1'b1;
            end else begin
              step <= i_idx;
            end
          end else begin
            phase <= PH_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  // Arithmetic working registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_PREP: begin
        i_idx  <= step + 1'b1;
        n_cnt  <= (cnt_mem[head] == '0) ? 16'd1 : cnt_mem[head];
        kind   <= kind_mem[head];
        more   <= (fill != '0);
        vel_en <= (fill != '0) && (phase == PH_PLAY);
        for (int a = 0; a < 2; a++) begin
          neg[a] <= dpos[a][32];
          mag[a] <= dpos[a][32] ? MAG_W'(-dpos[a]) : MAG_W'(dpos[a]);
          q[a]   <= '0;
          vel[a] <= '0;
        end
      end
      OP_MUL_I, OP_MUL_W, OP_MUL_V: prod <= prod_c;
      OP_DIV_LIN: begin
        dvd <= prod[DIV_W-1:0] + DIV_W'(n_cnt >> 1);
        rem <= '0;
      end
      OP_DIV_K: begin
        dvd <= DIV_W'(i_idx) * DIV_W'(COS_TABLE_SIZE) + DIV_W'(n_cnt >> 1);
        rem <= '0;
      end
      OP_DIV_STEP: begin
        if (rtry >= {1'b0, n_cnt}) begin
          rem <= 16'(rtry - {1'b0, n_cnt});
          dvd <= {dvd[DIV_W-2:0], 1'b1};
        end else begin
          rem <= rtry[15:0];
          dvd <= {dvd[DIV_W-2:0], 1'b0};
        end
      end
      OP_Q_LIN: q[cmd.ax] <= dvd[MAG_W-1:0];
      OP_TAB:   w <= WTAB[k_idx];
      OP_Q_COS: q[cmd.ax] <= vq[MAG_W-1:0];
      OP_NXT: begin
        for (int a = 0; a < 2; a++) begin
          nxt[a] <= 32'(34'(origin[a]) + (neg[a] ? -(34'(q[a])) : 34'(q[a])));
        end
      end
      OP_DIFF: begin
        for (int a = 0; a < 2; a++) begin
          if ((33'(nxt[a]) - 33'(prev[a])) >= 0) begin
            neg[a] <= 1'b0;
            mag[a] <= MAG_W'(33'(nxt[a]) - 33'(prev[a]));
          end else begin
            neg[a] <= 1'b1;
            mag[a] <= MAG_W'(33'(prev[a]) - 33'(nxt[a]));
          end
        end
      end
      OP_VEL: begin
        if (!neg[cmd.ax]) begin
          vel[cmd.ax] <= (vq > VQ_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : vq[31:0];
        end else begin
          vel[cmd.ax] <= (vq > VQ_W'(32'h8000_0000)) ? 32'sh8000_0000 : -(vq[31:0]);
        end
      end
      OP_OUT: begin
        m_tdata <= {vel[1], vel[0], cur[1], cur[0]};
        m_tlast <= !more;
        m_tuser <= ovf;
      end
      default: ;
    endcase
  end

  always_comb begin
    status.head_kind = kind_mem[head];
    status.kind      = kind;
    status.no_move   = (fill == '0);
    status.vel_en    = vel_en;
    status.div_done  = (dcnt == '0);
    status.out_free  = !m_tvalid || m_tready;
    status.play_done = (phase != PH_IDLE) && (phase != PH_PLAY);
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(MOVE_DEPTH))
    else $error("queue fill count beyond depth");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_ENQ && in_count != '0 && fill == FILL_W'(MOVE_DEPTH))
      |=> ovf && $stable(fill))
    else $error("move on full queue was not dropped and flagged");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_OUT && !more) |=> phase == PH_DONE && m_tvalid && m_tlast)
    else $error("final sample did not end playback");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (dcnt != '0) |-> rem < n_cnt)
    else $error("divider remainder not below divisor");

endmodule

// ===== rtl/cosine_trajectory_generator.sv =====
// Top level of the two-axis trajectory generator: configuration registers and wiring.
//
//   channel  direction  handshake          payload
//   s_*      in         s_tvalid/s_tready  tuser: action; tdata: end_pos_a, end_pos_b, steps
//   m_*      out        m_tvalid/m_tready  tdata: pos a/b, vel a/b; tlast: last; tuser: ovf
//   cfg_*    in         cfg_valid/ready    cfg_index, cfg_data
//
// A move command is queued from the idle state. The first sample skips the velocity
// steps. The 50-step serial divider is run once per axis for linear moves and once for
// the table index of cosine moves. Reset is synchronous and needs no clearing pass.
// A finished sample waits in the output register while the next input is taken;
// a second sample waits for that register to empty.
module cosine_trajectory_generator (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [79:0]  s_tdata,   // end_pos_a [31:0], end_pos_b [63:32], step_count [79:64]
  input  logic [1:0]   s_tuser,   // action [1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // set_pos_a, set_pos_b, set_vel_a, set_vel_b, 32 bits each
  output logic         m_tlast,
  output logic [0:0]   m_tuser,   // queue_overflow [0]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import ctg_pkg::*;

  logic signed [31:0] start_a, start_b;
  logic [23:0]        gain;
  ctg_cmd_t           cmd;
  ctg_status_t        status;
  action_t            in_action;

  assign cfg_ready = 1'b1;
  assign in_action = action_t'(s_tuser);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_a <= '0;
      start_b <= '0;
      gain    <= VEL_GAIN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_START_A:  start_a <= cfg_data;
        CFG_START_B:  start_b <= cfg_data;
        CFG_VEL_GAIN: gain    <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  ctg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .in_action (in_action),
    .s_tready  (s_tready),
    .status    (status),
    .cmd       (cmd)
  );

  ctg_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_action (in_action),
    .in_end_a  (s_tdata[31:0]),
    .in_end_b  (s_tdata[63:32]),
    .in_count  (s_tdata[79:64]),
    .start_a   (start_a),
    .start_b   (start_b),
    .gain      (gain),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule
